### rtl/lsel_pkg.sv
package lsel_pkg;

	// fixed field widths
	localparam int DIST_BITS   = 16;
	localparam int IDX_BITS    = 16;
	localparam int CNT_BITS    = 16;
	localparam int MAX_SAMPLES = 65535;
	localparam int PROD_BITS   = 2 * DIST_BITS;

	// configuration port
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [1:0]           side_t;
	typedef logic [1:0]           mode_t;
	typedef logic [1:0]           reg_idx_t;

	// boundary line modes
	localparam mode_t MODE_VERT = 2'd0;
	localparam mode_t MODE_HORZ = 2'd1;
	localparam mode_t MODE_DIAG = 2'd2;

	// register indexes
	localparam reg_idx_t REG_MODE  = 2'd0;
	localparam reg_idx_t REG_XI    = 2'd1;
	localparam reg_idx_t REG_YI    = 2'd2;
	localparam reg_idx_t REG_COUNT = 2'd3;

	// side codes, two's complement
	localparam side_t SIDE_ZERO = 2'b00;
	localparam side_t SIDE_POS  = 2'b01;
	localparam side_t SIDE_NEG  = 2'b11;

endpackage

### rtl/lsel_row_if.sv
interface lsel_row_if import lsel_pkg::*; ();
	logic  valid;
	logic  ready;
	dist_t core_dist;
	dist_t accessory_dist;
	logic  restart;

	modport source (output valid, core_dist, accessory_dist, restart, input ready);
	modport sink (input valid, core_dist, accessory_dist, restart, output ready);
endinterface

### rtl/lsel_result_if.sv
interface lsel_result_if import lsel_pkg::*; ();
	logic  valid;
	logic  ready;
	idx_t  sample_a;
	idx_t  sample_b;
	side_t side;
	logic  is_edge;
	logic  last_pair;

	modport source (output valid, sample_a, sample_b, side, is_edge, last_pair, input ready);
	modport sink (input valid, sample_a, sample_b, side, is_edge, last_pair, output ready);
endinterface

### rtl/line_side_edge_lister.sv
// Classifies the rows of a condensed pairwise distance list against a boundary line.
// rows:     one beat per row: core_dist, accessory_dist and restart, which marks the
//           first row of a new list and sets the pair walk back to (0,1).
// verdicts: one beat per row: the pair (sample_a, sample_b) of that row, the side
//           sign (-1, 0, +1), is_edge (side value at or below zero) and last_pair.
// APB port: line_mode at 0x0, x_icpt at 0x4, y_icpt at 0x8, sample_count
//           at 0xC. Writes complete in the access cycle, pready is tied high.
// A rows beat reaches verdicts through a first and a second stage: the first runs
// the pair counters and the three 16x16 products of the diagonal test, the second
// adds and compares them into the output register. One row is taken every cycle while
// verdicts is ready. When verdicts stalls, both stages hold and rows.ready drops only
// once both are full, so a finished verdict waiting at the output still lets an empty
// first stage take a row. Reset clears both stages, sets the pair walk to (0,1) and
// loads the registers with diagonal mode, zero intercepts and a sample count of two.
// Program the registers only while no row is in flight.
module line_side_edge_lister import lsel_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lsel_row_if.sink             rows,
	lsel_result_if.source        verdicts,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	localparam logic [CNT_BITS-1:0] CNT_MIN = CNT_BITS'(2);
	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_SAMPLES);

	// configuration registers
	mode_t               line_mode_q;
	dist_t               x_icpt_q;
	dist_t               y_icpt_q;
	logic [CNT_BITS-1:0] sample_count_q;

	// pair walk
	idx_t row_q;
	idx_t col_q;

	// first stage
	logic                 v_s1;
	idx_t                 row_s1;
	idx_t                 col_s1;
	logic                 last_s1;
	logic                 diag_s1;
	side_t                axis_side_s1;
	logic [PROD_BITS-1:0] p1_s1;
	logic [PROD_BITS-1:0] p2_s1;
	logic [PROD_BITS-1:0] pxy_s1;

	// output stage
	logic  v_s2;
	idx_t  row_s2;
	idx_t  col_s2;
	side_t side_s2;
	logic  last_s2;

	logic                 take;
	logic                 adv_s1;
	logic                 s2_free;
	logic [CNT_BITS-1:0]  n_eff;
	idx_t                 cur_row;
	idx_t                 cur_col;
	logic                 col_end;
	logic                 row_end;
	logic                 last_now;
	side_t                axis_side;
	logic [PROD_BITS:0]   diag_sum;
	side_t                diag_side;

	function automatic side_t cmp_sign(input logic [PROD_BITS:0] a, input logic [PROD_BITS:0] b);
		side_t s;
		if (a > b)
			s = SIDE_POS;
		else if (a < b)
			s = SIDE_NEG;
		else
			s = SIDE_ZERO;
		return s;
	endfunction

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q    <= MODE_DIAG;
			x_icpt_q       <= '0;
			y_icpt_q       <= '0;
			sample_count_q <= CNT_MIN;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_MODE:  line_mode_q    <= pwdata[1:0];
				REG_XI:    x_icpt_q       <= pwdata[DIST_BITS-1:0];
				REG_YI:    y_icpt_q       <= pwdata[DIST_BITS-1:0];
				REG_COUNT: sample_count_q <= pwdata[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_MODE:  prdata = DATA_BITS'(line_mode_q);
			REG_XI:    prdata = DATA_BITS'(x_icpt_q);
			REG_YI:    prdata = DATA_BITS'(y_icpt_q);
			REG_COUNT: prdata = DATA_BITS'(sample_count_q);
			default:   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- handshake
	// Each stage moves when it is empty or the one after it moves.
	assign s2_free    = !v_s2 || verdicts.ready;
	assign adv_s1     = v_s1 && s2_free;
	assign rows.ready = !v_s1 || s2_free;
	assign take       = rows.valid && rows.ready;

	// ---------------------------------------------------------------- pair walk
	// Clamp the count into the legal range of the walk.
	always_comb begin
		if (sample_count_q < CNT_MIN)
			n_eff = CNT_MIN;
		else if ({1'b0, sample_count_q} > (CNT_BITS+1)'(MAX_SAMPLES))
			n_eff = CNT_MAX;
		else
			n_eff = sample_count_q;
	end

	assign cur_row  = rows.restart ? '0 : row_q;
	assign cur_col  = rows.restart ? IDX_BITS'(1) : col_q;
	assign col_end  = ({1'b0, cur_col} + (IDX_BITS+1)'(1)) >= (IDX_BITS+1)'(n_eff);
	assign row_end  = ({1'b0, cur_row} + (IDX_BITS+1)'(2)) >= (IDX_BITS+1)'(n_eff);
	assign last_now = col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= IDX_BITS'(1);
		end else if (take) begin
			if (last_now) begin
				// wrap to the first pair
				row_q <= '0;
				col_q <= IDX_BITS'(1);
			end else if (!col_end) begin
				row_q <= cur_row;
				col_q <= cur_col + IDX_BITS'(1);
			end else begin
				// row done: move to (i+1, i+2)
				row_q <= cur_row + IDX_BITS'(1);
				col_q <= cur_row + IDX_BITS'(2);
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_comb begin
		case (line_mode_q)
			MODE_VERT: axis_side = cmp_sign((PROD_BITS+1)'(rows.core_dist),
				(PROD_BITS+1)'(x_icpt_q));
			MODE_HORZ: axis_side = cmp_sign((PROD_BITS+1)'(rows.accessory_dist),
				(PROD_BITS+1)'(y_icpt_q));
			default:   axis_side = SIDE_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rows.ready)
			v_s1 <= rows.valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_s1       <= cur_row;
			col_s1       <= cur_col;
			last_s1      <= last_now;
			diag_s1      <= (line_mode_q == MODE_DIAG);
			axis_side_s1 <= axis_side;
			p1_s1        <= PROD_BITS'(rows.accessory_dist) * PROD_BITS'(x_icpt_q);
			p2_s1        <= PROD_BITS'(rows.core_dist) * PROD_BITS'(y_icpt_q);
			pxy_s1       <= PROD_BITS'(x_icpt_q) * PROD_BITS'(y_icpt_q);
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Diagonal side value: y0*xi + x0*yi - xi*yi, taken as a compare of the sum.
	assign diag_sum  = {1'b0, p1_s1} + {1'b0, p2_s1};
	assign diag_side = cmp_sign(diag_sum, {1'b0, pxy_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (s2_free)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			side_s2 <= diag_s1 ? diag_side : axis_side_s1;
		end
	end

	assign verdicts.valid     = v_s2;
	assign verdicts.sample_a  = row_s2;
	assign verdicts.sample_b  = col_s2;
	assign verdicts.side      = side_s2;
	assign verdicts.is_edge   = (side_s2 != SIDE_POS);
	assign verdicts.last_pair = last_s2;

	// ---------------------------------------------------------------- checks
	a_walk_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < col_q)
		else $error("pair walk lost i < j");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_now |=> row_q == '0 && col_q == IDX_BITS'(1))
		else $error("pair walk did not wrap after the final pair");

	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> side_s2 == SIDE_POS || side_s2 == SIDE_ZERO || side_s2 == SIDE_NEG)
		else $error("illegal side code at the output");

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 || !v_s2 |-> rows.ready)
		else $error("input stalled with room in the pipeline");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && !verdicts.ready |=> v_s1 && v_s2)
		else $error("pipeline dropped a beat under backpressure");

endmodule
